@@ rtl/imq_pkg.sv @@
// Package for the indexed min-heap priority queue: widths, command and status
// codes, heap entry type and the controller/datapath command and status structs.
// Depends on nothing.
`timescale 1ns / 1ps

package imq_pkg;

	localparam int PRIO_W       = 8;
	localparam int PAY_W        = 32;
	localparam int TOP_W        = 9;
	localparam int ST_W         = 3;
	localparam int CMD_W        = 2;
	localparam int PRIO_RANGE   = 256;
	localparam int CAPACITY_DEF = 64;

	localparam logic [PRIO_W-1:0] MAXP_RESET = 8'hFF;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RAISE  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_LOWER  = 2'd3;

	localparam logic [ST_W-1:0] ST_OK      = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
	localparam logic [ST_W-1:0] ST_ABSENT  = 3'd3;
	localparam logic [ST_W-1:0] ST_PRESENT = 3'd4;

	// Heap memory read address selects.
	localparam logic [2:0] RD_NONE   = 3'd0;
	localparam logic [2:0] RD_ROOT   = 3'd1;
	localparam logic [2:0] RD_LAST   = 3'd2;
	localparam logic [2:0] RD_SLOT   = 3'd3;
	localparam logic [2:0] RD_PARENT = 3'd4;
	localparam logic [2:0] RD_CHILD  = 3'd5;
	localparam logic [2:0] RD_CHILD1 = 3'd6;

	typedef struct packed {
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
	} entry_t;

	typedef struct packed {
		logic            load_in;
		logic            set_status;
		logic [ST_W-1:0] status_code;
		logic            ins_setup;
		logic            rm_take_root;
		logic            rm_take_last;
		logic            rl_setup;
		logic            rl_load;
		logic [2:0]      rd_op;
		logic            mv_parent;
		logic            sd_first;
		logic            sd_second;
		logic            mv_child;
		logic            place;
		logic            load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             full;
		logic             empty;
		logic             present;
		logic             tgt_same;
		logic             tgt_taken;
		logic             last_one;
		logic             at_root;
		logic             parent_gt;
		logic             no_child;
		logic             has_child1;
		logic             child_lt;
		logic             out_free;
	} ctrl_stat_t;

endpackage

@@ rtl/imq_if.sv @@
// Handshake interfaces for the request and response channels of the queue.
// Depends on imq_pkg for field widths.
`timescale 1ns / 1ps

interface imq_req_if;
	logic                       valid;
	logic                       ready;
	logic [imq_pkg::CMD_W-1:0]  cmd;
	logic [imq_pkg::PRIO_W-1:0] prio;
	logic [imq_pkg::PAY_W-1:0]  payload;

	modport source (output valid, output cmd, output prio, output payload, input ready);
	modport sink (input valid, input cmd, input prio, input payload, output ready);
endinterface

interface imq_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [imq_pkg::ST_W-1:0]  status;
	logic [imq_pkg::TOP_W-1:0] top_prio;
	logic [imq_pkg::PAY_W-1:0] top_payload;
	logic                      is_empty;
	logic                      is_full;
	logic                      prio_present;

	modport source (output valid, output status, output top_prio, output top_payload,
		output is_empty, output is_full, output prio_present, input ready);
	modport sink (input valid, input status, input top_prio, input top_payload,
		input is_empty, input is_full, input prio_present, output ready);
endinterface

@@ rtl/imq_ctrl.sv @@
// Controller state machine of the queue: sequences each command through the
// heap datapath. Depends on imq_pkg for the command and status structs.
`timescale 1ns / 1ps

module imq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  imq_pkg::ctrl_stat_t stat,
	output imq_pkg::ctrl_cmd_t  ctl
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_EVAL   = 4'd1;
	localparam logic [3:0] S_RM1    = 4'd2;
	localparam logic [3:0] S_RM2    = 4'd3;
	localparam logic [3:0] S_RL1    = 4'd4;
	localparam logic [3:0] S_SU_RD  = 4'd5;
	localparam logic [3:0] S_SU_CMP = 4'd6;
	localparam logic [3:0] S_SD_RD1 = 4'd7;
	localparam logic [3:0] S_SD_RD2 = 4'd8;
	localparam logic [3:0] S_SD_RD3 = 4'd9;
	localparam logic [3:0] S_SD_CMP = 4'd10;
	localparam logic [3:0] S_PLACE  = 4'd11;
	localparam logic [3:0] S_TOP    = 4'd12;
	localparam logic [3:0] S_FIN    = 4'd13;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		ctl.rd_op = imq_pkg::RD_NONE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load_in = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				case (stat.cmd)
					imq_pkg::CMD_INSERT: begin
						if (stat.full) begin
							ctl.set_status  = 1'b1;
							ctl.status_code = imq_pkg::ST_FULL;
							state_d         = S_TOP;
						end else if (stat.present) begin
							ctl.set_status  = 1'b1;
							ctl.status_code = imq_pkg::ST_PRESENT;
							state_d         = S_TOP;
						end else begin
							ctl.ins_setup = 1'b1;
							state_d       = S_SU_RD;
						end
					end
					imq_pkg::CMD_REMOVE: begin
						if (stat.empty) begin
							ctl.set_status  = 1'b1;
							ctl.status_code = imq_pkg::ST_EMPTY;
							state_d         = S_TOP;
						end else begin
							ctl.rd_op = imq_pkg::RD_ROOT;
							state_d   = S_RM1;
						end
					end
					default: begin
						if (!stat.present) begin
							ctl.set_status  = 1'b1;
							ctl.status_code = imq_pkg::ST_ABSENT;
							state_d         = S_TOP;
						end else if (stat.tgt_same) begin
							state_d = S_TOP;
						end else if (stat.tgt_taken) begin
							ctl.set_status  = 1'b1;
							ctl.status_code = imq_pkg::ST_PRESENT;
							state_d         = S_TOP;
						end else begin
							ctl.rl_setup = 1'b1;
							ctl.rd_op    = imq_pkg::RD_SLOT;
							state_d      = S_RL1;
						end
					end
				endcase
			end
			S_RM1: begin
				ctl.rm_take_root = 1'b1;
				ctl.rd_op        = imq_pkg::RD_LAST;
				state_d          = S_RM2;
			end
			S_RM2: begin
				ctl.rm_take_last = 1'b1;
				state_d          = stat.last_one ? S_TOP : S_SD_RD1;
			end
			S_RL1: begin
				ctl.rl_load = 1'b1;
				state_d     = S_SU_RD;
			end
			S_SU_RD: begin
				if (stat.at_root) begin
					state_d = S_SD_RD1;
				end else begin
					ctl.rd_op = imq_pkg::RD_PARENT;
					state_d   = S_SU_CMP;
				end
			end
			S_SU_CMP: begin
				if (stat.parent_gt) begin
					ctl.mv_parent = 1'b1;
					state_d       = S_SU_RD;
				end else begin
					state_d = S_SD_RD1;
				end
			end
			S_SD_RD1: begin
				if (stat.no_child) begin
					state_d = S_PLACE;
				end else begin
					ctl.rd_op = imq_pkg::RD_CHILD;
					state_d   = S_SD_RD2;
				end
			end
			S_SD_RD2: begin
				ctl.sd_first = 1'b1;
				if (stat.has_child1) begin
					ctl.rd_op = imq_pkg::RD_CHILD1;
					state_d   = S_SD_RD3;
				end else begin
					state_d = S_SD_CMP;
				end
			end
			S_SD_RD3: begin
				ctl.sd_second = 1'b1;
				state_d       = S_SD_CMP;
			end
			S_SD_CMP: begin
				if (stat.child_lt) begin
					ctl.mv_child = 1'b1;
					state_d      = S_SD_RD1;
				end else begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				ctl.place = 1'b1;
				state_d   = S_TOP;
			end
			S_TOP: begin
				ctl.rd_op = imq_pkg::RD_ROOT;
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/imq_dpath.sv @@
// Datapath of the queue: heap memory, priority-to-slot map with presence bits,
// count, sift registers and the response register. Depends on imq_pkg, imq_if.
`timescale 1ns / 1ps

module imq_dpath #(
	parameter int CAPACITY = imq_pkg::CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [imq_pkg::PRIO_W-1:0] cfg_wdata,
	imq_req_if.sink                    req,
	imq_rsp_if.source                  rsp,
	input  imq_pkg::ctrl_cmd_t         ctl,
	output imq_pkg::ctrl_stat_t        stat
);

	localparam int SW = $clog2(CAPACITY + 1);
	localparam logic [SW-1:0] CAP_V = SW'(CAPACITY);
	localparam logic [SW-1:0] ONE_V = SW'(1);

	logic [imq_pkg::CMD_W-1:0]  cmd_q;
	logic [imq_pkg::PRIO_W-1:0] prio_q;
	logic [imq_pkg::PAY_W-1:0]  pay_q;
	logic [imq_pkg::PRIO_W-1:0] target_q;
	logic                       present_q;
	logic [imq_pkg::ST_W-1:0]   status_q;
	logic [imq_pkg::PRIO_W-1:0] maxp_q;
	logic [SW-1:0]              count_q;
	logic [SW-1:0]              idx_q;
	logic [SW-1:0]              cidx_q;
	imq_pkg::entry_t            e_q;
	imq_pkg::entry_t            child_q;
	imq_pkg::entry_t            rdata_q;
	imq_pkg::entry_t            heap_mem [CAPACITY+1];
	logic [SW-1:0]              map_mem [imq_pkg::PRIO_RANGE];
	logic [SW-1:0]              map_rdata_q;
	logic [imq_pkg::PRIO_RANGE-1:0] valid_q;

	logic [imq_pkg::PRIO_W:0]   sum;
	logic [imq_pkg::PRIO_W-1:0] target_d;
	logic [SW:0]                c_addr;
	logic [SW:0]                c1_addr;
	logic [SW-1:0]              raddr;
	logic                       heap_we;
	imq_pkg::entry_t            wdata;

	logic                       out_valid_q;
	logic [imq_pkg::ST_W-1:0]   out_status_q;
	logic [imq_pkg::TOP_W-1:0]  out_top_prio_q;
	logic [imq_pkg::PAY_W-1:0]  out_top_pay_q;
	logic                       out_empty_q;
	logic                       out_full_q;
	logic                       out_present_q;

	// New priority for raise (halve) or lower (midpoint toward max_priority).
	assign sum = {1'b0, req.prio} + {1'b0, maxp_q};
	always_comb begin
		if (req.cmd == imq_pkg::CMD_RAISE) begin
			target_d = {1'b0, req.prio[imq_pkg::PRIO_W-1:1]};
		end else if (req.prio >= maxp_q) begin
			target_d = req.prio;
		end else begin
			target_d = sum[imq_pkg::PRIO_W:1];
		end
	end

	assign c_addr  = {idx_q, 1'b0};
	assign c1_addr = {idx_q, 1'b1};

	always_comb begin
		case (ctl.rd_op)
			imq_pkg::RD_ROOT:   raddr = ONE_V;
			imq_pkg::RD_LAST:   raddr = count_q;
			imq_pkg::RD_SLOT:   raddr = map_rdata_q;
			imq_pkg::RD_PARENT: raddr = idx_q >> 1;
			imq_pkg::RD_CHILD:  raddr = c_addr[SW-1:0];
			imq_pkg::RD_CHILD1: raddr = c1_addr[SW-1:0];
			default:            raddr = ONE_V;
		endcase
	end

	assign heap_we = ctl.mv_parent | ctl.mv_child | ctl.place;
	always_comb begin
		if (ctl.mv_parent) begin
			wdata = rdata_q;
		end else if (ctl.mv_child) begin
			wdata = child_q;
		end else begin
			wdata = e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (heap_we) begin
			heap_mem[idx_q] <= wdata;
			map_mem[wdata.prio] <= idx_q;
		end
		if (ctl.rd_op != imq_pkg::RD_NONE) begin
			rdata_q <= heap_mem[raddr];
		end
		if (ctl.load_in) begin
			map_rdata_q <= map_mem[req.prio];
		end
	end

	// Payload and working registers.
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q     <= req.cmd;
			prio_q    <= req.prio;
			pay_q     <= req.payload;
			target_q  <= target_d;
			present_q <= valid_q[req.prio];
		end
		if (ctl.ins_setup) begin
			idx_q <= count_q + ONE_V;
			e_q   <= '{prio: prio_q, payload: pay_q};
		end
		if (ctl.rl_setup) begin
			idx_q <= map_rdata_q;
		end
		if (ctl.rl_load) begin
			e_q <= '{prio: target_q, payload: rdata_q.payload};
		end
		if (ctl.rm_take_last) begin
			e_q   <= rdata_q;
			idx_q <= ONE_V;
		end
		if (ctl.mv_parent) begin
			idx_q <= idx_q >> 1;
		end
		if (ctl.sd_first) begin
			child_q <= rdata_q;
			cidx_q  <= c_addr[SW-1:0];
		end
		if (ctl.sd_second && (rdata_q.prio < child_q.prio)) begin
			child_q <= rdata_q;
			cidx_q  <= c1_addr[SW-1:0];
		end
		if (ctl.mv_child) begin
			idx_q <= cidx_q;
		end
	end

	// Control state: count, presence bits, status, config register, response.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_q     <= '0;
			status_q    <= imq_pkg::ST_OK;
			maxp_q      <= imq_pkg::MAXP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				maxp_q <= cfg_wdata;
			end
			if (ctl.load_in) begin
				status_q <= imq_pkg::ST_OK;
			end else if (ctl.set_status) begin
				status_q <= ctl.status_code;
			end
			if (ctl.ins_setup) begin
				count_q <= count_q + ONE_V;
			end else if (ctl.rm_take_last) begin
				count_q <= count_q - ONE_V;
			end
			if (ctl.rm_take_root) begin
				valid_q[rdata_q.prio] <= 1'b0;
			end else if (ctl.rl_setup) begin
				valid_q[prio_q] <= 1'b0;
			end else if (ctl.place) begin
				valid_q[e_q.prio] <= 1'b1;
			end
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_status_q   <= status_q;
			out_empty_q    <= (count_q == '0);
			out_full_q     <= (count_q == CAP_V);
			out_present_q  <= present_q;
			if (count_q == '0) begin
				out_top_prio_q <= imq_pkg::TOP_W'(imq_pkg::PRIO_RANGE);
				out_top_pay_q  <= '0;
			end else begin
				out_top_prio_q <= {1'b0, rdata_q.prio};
				out_top_pay_q  <= rdata_q.payload;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.top_prio     = out_top_prio_q;
	assign rsp.top_payload  = out_top_pay_q;
	assign rsp.is_empty     = out_empty_q;
	assign rsp.is_full      = out_full_q;
	assign rsp.prio_present = out_present_q;

	assign stat.cmd        = cmd_q;
	assign stat.full       = (count_q == CAP_V);
	assign stat.empty      = (count_q == '0);
	assign stat.present    = present_q;
	assign stat.tgt_same   = (target_q == prio_q);
	assign stat.tgt_taken  = valid_q[target_q];
	assign stat.last_one   = (count_q == ONE_V);
	assign stat.at_root    = (idx_q == ONE_V);
	assign stat.parent_gt  = (rdata_q.prio > e_q.prio);
	assign stat.no_child   = (c_addr > {1'b0, count_q});
	assign stat.has_child1 = (c1_addr <= {1'b0, count_q});
	assign stat.child_lt   = (child_q.prio < e_q.prio);
	assign stat.out_free   = !out_valid_q || rsp.ready;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_V) else $error("entry count above capacity");
	a_place_slot: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.place |-> (idx_q != '0) && (idx_q <= count_q))
		else $error("entry placed outside the filled slots");
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> out_valid_q) else $error("response not held after load");
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_empty_q |->
		out_top_prio_q == imq_pkg::TOP_W'(imq_pkg::PRIO_RANGE))
		else $error("empty response with a top priority");
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins_setup |=> count_q == $past(count_q) + ONE_V)
		else $error("insert did not grow the count");
`endif

endmodule

@@ rtl/indexed_min_heap_priority_queue.sv @@
// Top level of the indexed min-heap priority queue: the controller and the
// datapath joined by command and status structs. Depends on imq_pkg, imq_if.
//
// The queue holds up to CAPACITY (priority, payload) entries with distinct
// 8-bit priorities in a binary min-heap, plus a map from each priority to its
// heap slot so that an entry can be found by priority. Each request
// transaction (insert, remove minimum, raise to p/2, lower to the midpoint of
// p and max_priority) produces exactly one response transaction with a status,
// the smallest priority and its payload after the command, the empty and full
// flags, and whether the requested priority was held beforehand. A failing
// command leaves the heap unchanged. The heap lives in a single-port-read
// memory with registered read data, so each sift level costs memory reads:
// sift-up reads the parent and then compares, and sift-down reads one or two
// children and then compares. A new request is taken only when the previous
// command has finished its heap work, while its response may still be waiting
// in the output register; a stalled response holds the next command in its
// last state until the register frees. The max_priority register is
// written through cfg_we/cfg_wdata and should only be changed while idle.
`timescale 1ns / 1ps

module indexed_min_heap_priority_queue #(
	parameter int CAPACITY = imq_pkg::CAPACITY_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [imq_pkg::PRIO_W-1:0] cfg_wdata,
	imq_req_if.sink                    req,
	imq_rsp_if.source                  rsp
);

	imq_pkg::ctrl_cmd_t  ctl;
	imq_pkg::ctrl_stat_t stat;

	// The controller sees only the request valid; the datapath owns payloads.
	imq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	imq_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.ctl       (ctl),
		.stat      (stat)
	);

endmodule

@@ tb/imq_scoreboard.sv @@
// Checker for the indexed min-heap priority queue: watches the request and
// response channels, predicts each response and compares it field by field.
// Depends on imq_pkg and the interfaces in imq_if.sv.
`timescale 1ns / 1ps

module imq_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	imq_req_if.sink     req,
	imq_rsp_if.sink     rsp,
	output int          fail_count,
	output int          pending
);
	import imq_pkg::*;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [TOP_W-1:0] top_prio;
		logic [PAY_W-1:0] top_payload;
		logic             is_empty;
		logic             is_full;
		logic             prio_present;
	} answer_t;

	localparam int CAP = CAPACITY_DEF;

	logic [8:0]       h_prio [0:CAP];
	logic [PAY_W-1:0] h_pay [0:CAP];
	int               slot_of [0:PRIO_RANGE];
	int               count;
	logic [7:0]       maxp;
	answer_t          answers [$];

	assign pending = answers.size();

	function automatic void swap_entries(int a, int b);
		logic [8:0] tp;
		logic [PAY_W-1:0] td;
		tp = h_prio[a]; td = h_pay[a];
		h_prio[a] = h_prio[b]; h_pay[a] = h_pay[b];
		h_prio[b] = tp; h_pay[b] = td;
		slot_of[h_prio[a]] = a;
		slot_of[h_prio[b]] = b;
	endfunction

	function automatic void bubble_up(int i);
		while (i > 1 && h_prio[i/2] > h_prio[i]) begin
			swap_entries(i/2, i);
			i = i/2;
		end
	endfunction

	function automatic void bubble_down(int i);
		int c;
		forever begin
			c = 2*i;
			if (c > count) break;
			if (c+1 <= count && h_prio[c+1] < h_prio[c]) c++;
			if (h_prio[c] < h_prio[i]) begin
				swap_entries(i, c);
				i = c;
			end else break;
		end
	endfunction

	function automatic answer_t apply_command(logic [1:0] op, logic [7:0] p, logic [31:0] pay);
		answer_t a;
		logic present;
		logic [ST_W-1:0] st;
		int tgt, s, last;
		present = slot_of[p] != 0;
		st = ST_OK;
		case (op)
			CMD_INSERT: begin
				if (count >= CAP) st = ST_FULL;
				else if (present) st = ST_PRESENT;
				else begin
					count++;
					h_prio[count] = {1'b0, p}; h_pay[count] = pay;
					slot_of[p] = count;
					bubble_up(count);
				end
			end
			CMD_REMOVE: begin
				if (count == 0) st = ST_EMPTY;
				else begin
					last = count;
					slot_of[h_prio[1]] = 0;
					if (last > 1) begin
						h_prio[1] = h_prio[last]; h_pay[1] = h_pay[last];
						slot_of[h_prio[1]] = 1;
					end
					h_prio[last] = 9'(PRIO_RANGE);
					count = last - 1;
					bubble_down(1);
				end
			end
			default: begin
				if (!present) st = ST_ABSENT;
				else begin
					if (op == CMD_RAISE) tgt = p / 2;
					else if (p >= maxp) tgt = p;
					else tgt = (int'(p) + int'(maxp)) / 2;
					if (tgt > PRIO_RANGE-1) tgt = PRIO_RANGE-1;
					if (tgt != p) begin
						if (slot_of[tgt] != 0) st = ST_PRESENT;
						else begin
							s = slot_of[p];
							slot_of[p] = 0;
							h_prio[s] = 9'(tgt);
							slot_of[tgt] = s;
							bubble_up(s);
							bubble_down(slot_of[tgt]);
						end
					end
				end
			end
		endcase
		a.status = st;
		a.top_prio = count ? h_prio[1] : 9'(PRIO_RANGE);
		a.top_payload = count ? h_pay[1] : '0;
		a.is_empty = count == 0;
		a.is_full = count == CAP;
		a.prio_present = present;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t e;
		if (!arst_n) begin
			for (int i = 0; i <= CAP; i++) begin
				h_prio[i] = 9'(PRIO_RANGE);
				h_pay[i] = '0;
			end
			for (int i = 0; i <= PRIO_RANGE; i++) slot_of[i] = 0;
			count = 0;
			maxp = MAXP_RESET;
			fail_count = 0;
			answers.delete();
		end else begin
			if (cfg_we) maxp = cfg_wdata;
			if (req.valid && req.ready)
				answers.push_back(apply_command(req.cmd, req.prio, req.payload));
			if (rsp.valid && rsp.ready) begin
				if (answers.size() == 0) begin
					$error("response with no command outstanding");
					fail_count++;
				end else begin
					e = answers.pop_front();
					if (rsp.status !== e.status) begin
						$error("status: expected %0d, got %0d", e.status, rsp.status);
						fail_count++;
					end
					if (rsp.top_prio !== e.top_prio) begin
						$error("top_prio: expected %0d, got %0d", e.top_prio, rsp.top_prio);
						fail_count++;
					end
					// The top payload reads as zero when the heap is empty.
					if (rsp.top_payload !== e.top_payload) begin
						$error("top_payload: expected %h, got %h", e.top_payload,
							rsp.top_payload);
						fail_count++;
					end
					if (rsp.is_empty !== e.is_empty) begin
						$error("is_empty: expected %0d, got %0d", e.is_empty, rsp.is_empty);
						fail_count++;
					end
					if (rsp.is_full !== e.is_full) begin
						$error("is_full: expected %0d, got %0d", e.is_full, rsp.is_full);
						fail_count++;
					end
					if (rsp.prio_present !== e.prio_present) begin
						$error("prio_present: expected %0d, got %0d", e.prio_present,
							rsp.prio_present);
						fail_count++;
					end
				end
			end
		end
	end
endmodule

@@ tb/indexed_min_heap_priority_queue_tb.sv @@
// Top of the queue testbench: clock, reset, request stimulus, response stalls,
// max_priority changes and the verdict. Depends on imq_pkg, imq_if,
// imq_scoreboard and the block.
`timescale 1ns / 1ps

module indexed_min_heap_priority_queue_tb;
	import imq_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       steady;
	int         fail_count;
	int         pending;

	imq_req_if req ();
	imq_rsp_if rsp ();

	indexed_min_heap_priority_queue uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp)
	);

	imq_scoreboard checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp), .fail_count(fail_count), .pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// The response side stalls about 36% of cycles, except in steady stretches.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= steady || ($urandom_range(99) >= 36);
		end
	end

	// Sends one command transaction, idling first at random. After acceptance
	// valid stays up until the next transaction or an idle cycle replaces it,
	// so valid gets at most one assignment per time step.
	task automatic send_command(logic [1:0] op, logic [7:0] p, logic [31:0] pay);
		while (!steady && $urandom_range(99) < 36) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= op;
		req.prio <= p;
		req.payload <= pay;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	// Waits until every response has arrived, then lets the heap work drain,
	// so max_priority can be written while the block is idle.
	task automatic drain_queue();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_max_priority(logic [7:0] v);
		drain_queue();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random traffic. Priorities are mostly drawn from a narrow window so that
	// raise, lower and duplicate checks hit held entries; inserts dominate
	// while filling, removes while draining, so full and empty are reached.
	task automatic random_phase(int n, int fill_bias);
		logic [1:0] op;
		logic [7:0] p;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < fill_bias) op = CMD_INSERT;
			else if (r < fill_bias + 20) op = CMD_REMOVE;
			else op = $urandom_range(1) ? CMD_RAISE : CMD_LOWER;
			if ($urandom_range(3) == 0) p = 8'($urandom);
			else p = 8'($urandom_range(95));
			send_command(op, p, $urandom);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		steady = 1'b0;
		req.valid = 1'b0;
		req.cmd = CMD_INSERT;
		req.prio = '0;
		req.payload = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: errors on the empty heap, field extremes, every command.
		send_command(CMD_REMOVE, 8'd0, '0);
		send_command(CMD_RAISE, 8'd5, '0);
		send_command(CMD_LOWER, 8'd5, '0);
		send_command(CMD_INSERT, 8'd255, 32'hFFFF_FFFF);
		send_command(CMD_INSERT, 8'd0, 32'h0);
		send_command(CMD_INSERT, 8'd0, 32'h1234_5678);
		send_command(CMD_RAISE, 8'd0, '0);
		send_command(CMD_LOWER, 8'd255, '0);
		send_command(CMD_INSERT, 8'd100, 32'hA5A5_5A5A);
		send_command(CMD_INSERT, 8'd50, 32'h5A5A_A5A5);
		send_command(CMD_RAISE, 8'd100, '0);
		send_command(CMD_RAISE, 8'd50, '0);
		send_command(CMD_LOWER, 8'd25, '0);
		send_command(CMD_LOWER, 8'd140, '0);
		send_command(CMD_RAISE, 8'd77, '0);
		send_command(CMD_REMOVE, 8'd255, '0);
		send_command(CMD_REMOVE, 8'd0, '0);
		send_command(CMD_REMOVE, 8'd0, '0);
		send_command(CMD_REMOVE, 8'd0, '0);
		send_command(CMD_REMOVE, 8'd0, '0);
		send_command(CMD_REMOVE, 8'd0, '0);

		// Fill to capacity with one insert over, then try one more insert.
		for (int i = 0; i < 65; i++) send_command(CMD_INSERT, 8'(i * 3), $urandom);
		send_command(CMD_INSERT, 8'd1, '0);

		// Pause until every response is back, then run with max_priority at 0.
		write_max_priority(8'd0);
		send_command(CMD_LOWER, 8'd3, '0);
		random_phase(300, 25);

		write_max_priority(8'd200);
		steady = 1'b1;
		random_phase(300, 40);
		steady = 1'b0;

		write_max_priority(8'd255);
		random_phase(400, 55);
		random_phase(300, 15);

		write_max_priority(8'd60);
		random_phase(400, 45);

		write_max_priority(8'(1 + $urandom_range(254)));
		random_phase(300, 35);

		drain_queue();
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end
endmodule
